/* rtl/atxps_pkg.sv */
package atxps_pkg;

  typedef enum logic [2:0] {
    PH_HALT     = 3'd0,
    PH_PREWAIT  = 3'd1,
    PH_AWAIT    = 3'd2,
    PH_SETTLE   = 3'd3,
    PH_RUN      = 3'd4,
    PH_DROP     = 3'd5,
    PH_RELEASE  = 3'd6,
    PH_DEBOUNCE = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    CFG_PREWAIT  = 3'd0,
    CFG_SETTLE   = 3'd1,
    CFG_HOLD_LIM = 3'd2,
    CFG_DROP_TO  = 3'd3,
    CFG_DEBOUNCE = 3'd4
  } cfg_idx_t;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [4:0] WarmCauses = 5'h1E;
  localparam logic [2:0] BlinkMask = 3'h7;

  localparam logic [7:0]  PrewaitRst  = 8'd100;
  localparam logic [7:0]  SettleRst   = 8'd50;
  localparam logic [15:0] HoldLimRst  = 16'd1700;
  localparam logic [7:0]  DropToRst   = 8'd100;
  localparam logic [7:0]  DebounceRst = 8'd10;

  typedef struct packed {
    logic [7:0]  prewait_ticks;
    logic [7:0]  settle_ticks;
    logic [15:0] hold_limit;
    logic [7:0]  drop_timeout_ticks;
    logic [7:0]  debounce_ticks;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  tick_left;
    logic        button_seen;
    logic        off_by_button;
    logic [15:0] previous_hold;
    logic        supply;
    logic        led;
    logic        led_off;
  } seq_state_t;

  typedef struct packed {
    logic kind;
    logic [4:0] reset_cause;
    logic power_absent;
    logic button_down;
    logic [15:0] hold_count;
  } seq_in_t;

  typedef struct packed {
    logic cpu_soft_reset;
    logic power_cut;
  } seq_pulse_t;

endpackage

/* rtl/atxps_step.sv */
// Next-state logic for one word: a restart or one tick.
module atxps_step (
  input  atxps_pkg::cfg_t       cfg,
  input  atxps_pkg::seq_state_t cur,
  input  atxps_pkg::seq_in_t    din,
  output atxps_pkg::seq_state_t nxt,
  output atxps_pkg::seq_pulse_t pulse
);

  logic [7:0] tick_dec;
  logic       dec_zero;
  logic       cold;
  logic       seen_nxt;

  assign tick_dec = cur.tick_left - 8'd1;
  assign dec_zero = (tick_dec == 8'd0);
  assign cold     = ((din.reset_cause & atxps_pkg::WarmCauses) == 5'd0) || din.reset_cause[0];
  assign seen_nxt = cur.button_seen | din.button_down;

  always_comb begin
    nxt   = cur;
    pulse = '0;
    if (!din.kind) begin
      nxt.led     = 1'b0;
      nxt.led_off = 1'b0;
      if (!din.power_absent) begin
        nxt.phase = atxps_pkg::PH_RUN;
      end else if (cold) begin
        nxt.phase       = atxps_pkg::PH_PREWAIT;
        nxt.tick_left   = cfg.prewait_ticks;
        nxt.button_seen = 1'b0;
      end else begin
        nxt.supply    = 1'b1;
        nxt.phase     = atxps_pkg::PH_SETTLE;
        nxt.tick_left = cfg.settle_ticks;
      end
    end else begin
      unique case (cur.phase)
        atxps_pkg::PH_PREWAIT: begin
          nxt.led         = |(cur.tick_left[2:0] & atxps_pkg::BlinkMask);
          nxt.button_seen = seen_nxt;
          nxt.tick_left   = tick_dec;
          if (dec_zero) begin
            if (seen_nxt) begin
              nxt.supply    = 1'b1;
              nxt.phase     = atxps_pkg::PH_SETTLE;
              nxt.tick_left = cfg.settle_ticks;
            end else begin
              nxt.phase = atxps_pkg::PH_AWAIT;
            end
          end
        end
        atxps_pkg::PH_AWAIT: begin
          if (din.button_down) begin
            nxt.supply    = 1'b1;
            nxt.phase     = atxps_pkg::PH_SETTLE;
            nxt.tick_left = cfg.settle_ticks;
          end
        end
        atxps_pkg::PH_SETTLE: begin
          nxt.tick_left = tick_dec;
          if (dec_zero) begin
            nxt.phase = atxps_pkg::PH_RUN;
          end
        end
        atxps_pkg::PH_RUN: begin
          if (din.hold_count > cfg.hold_limit) begin
            nxt.off_by_button = din.button_down;
            nxt.supply        = 1'b0;
            nxt.phase         = atxps_pkg::PH_DROP;
            nxt.tick_left     = cfg.drop_timeout_ticks;
          end else if ((cur.previous_hold != 16'd0) && (din.hold_count == 16'd0)) begin
            pulse.cpu_soft_reset = 1'b1;
          end
          nxt.previous_hold = din.hold_count;
        end
        atxps_pkg::PH_DROP: begin
          // The timeout counter only moves when the supply is still present.
          if (!din.power_absent) begin
            nxt.tick_left = tick_dec;
          end
          if (din.power_absent || dec_zero) begin
            if (cur.off_by_button) begin
              nxt.phase = atxps_pkg::PH_RELEASE;
            end else begin
              nxt.led_off     = 1'b1;
              nxt.phase       = atxps_pkg::PH_HALT;
              pulse.power_cut = 1'b1;
            end
          end
        end
        atxps_pkg::PH_RELEASE: begin
          if (!din.button_down) begin
            nxt.phase     = atxps_pkg::PH_DEBOUNCE;
            nxt.tick_left = cfg.debounce_ticks;
          end
        end
        atxps_pkg::PH_DEBOUNCE: begin
          nxt.tick_left = tick_dec;
          if (dec_zero) begin
            nxt.led_off     = 1'b1;
            nxt.phase       = atxps_pkg::PH_HALT;
            pulse.power_cut = 1'b1;
          end
        end
        atxps_pkg::PH_HALT: begin
          nxt = cur;
        end
        default: begin
          nxt = cur;
        end
      endcase
    end
  end

endmodule

/* rtl/atx_power_sequencer.sv */
// The result word is registered: each accepted word lands in the result register.
// Throughput: one word per cycle unless out_ready stalls a full output register;
// it frees itself in the same cycle its result is taken, so in_ready stays high.
// Reset (rst_n low, synchronous): phase halted, all counters and flags zero,
// supply off, registers back to their default values, output register empty.
module atx_power_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [atxps_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [atxps_pkg::CfgDataW-1:0] cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [4:0]  in_reset_cause,
  input  logic        in_power_absent,
  input  logic        in_button_down,
  input  logic [15:0] in_hold_count,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_supply_on,
  output logic        out_led_on,
  output logic        out_led_disabled,
  output logic        out_cpu_soft_reset,
  output logic        out_hard_reset,
  output logic [2:0]  out_phase
);

  atxps_pkg::cfg_t       cfg_r;
  atxps_pkg::seq_state_t state_r;
  atxps_pkg::seq_state_t state_nxt;
  atxps_pkg::seq_pulse_t pulse_nxt;
  atxps_pkg::seq_in_t    din;
  atxps_pkg::seq_pulse_t pulse_r;
  logic                  out_valid_r;
  logic                  accept;

  // Configuration registers: a write lands at once; unknown indexes drop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prewait_ticks      <= atxps_pkg::PrewaitRst;
      cfg_r.settle_ticks       <= atxps_pkg::SettleRst;
      cfg_r.hold_limit         <= atxps_pkg::HoldLimRst;
      cfg_r.drop_timeout_ticks <= atxps_pkg::DropToRst;
      cfg_r.debounce_ticks     <= atxps_pkg::DebounceRst;
    end else if (cfg_we) begin
      case (cfg_index)
        atxps_pkg::CFG_PREWAIT:  cfg_r.prewait_ticks      <= cfg_wdata[7:0];
        atxps_pkg::CFG_SETTLE:   cfg_r.settle_ticks       <= cfg_wdata[7:0];
        atxps_pkg::CFG_HOLD_LIM: cfg_r.hold_limit         <= cfg_wdata;
        atxps_pkg::CFG_DROP_TO:  cfg_r.drop_timeout_ticks <= cfg_wdata[7:0];
        atxps_pkg::CFG_DEBOUNCE: cfg_r.debounce_ticks     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Take a new word whenever the result register is empty or being drained.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign din.kind         = in_kind;
  assign din.reset_cause  = in_reset_cause;
  assign din.power_absent = in_power_absent;
  assign din.button_down  = in_button_down;
  assign din.hold_count   = in_hold_count;

  atxps_step u_step (
    .cfg   (cfg_r),
    .cur   (state_r),
    .din   (din),
    .nxt   (state_nxt),
    .pulse (pulse_nxt)
  );

  // Sequencer state: advance only on an accepted word, otherwise hold.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  // Result register: pulses are captured with the state they belong to.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pulse_r     <= '0;
    end else begin
      if (accept) begin
        out_valid_r <= 1'b1;
        pulse_r     <= pulse_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Level outputs come straight from the state register, which moves only
  // together with the result register.
  assign out_valid          = out_valid_r;
  assign out_supply_on      = state_r.supply;
  assign out_led_on         = state_r.led;
  assign out_led_disabled   = state_r.led_off;
  assign out_cpu_soft_reset = pulse_r.cpu_soft_reset;
  assign out_hard_reset     = pulse_r.power_cut;
  assign out_phase          = state_r.phase;

endmodule

/* rtl/atxps_checker.sv */
module atxps_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_supply_on,
  input logic       out_led_disabled,
  input logic       out_cpu_soft_reset,
  input logic       out_hard_reset,
  input logic [2:0] out_phase
);

  // A completed shutdown leaves the block halted with the LED cut off.
  a_hard_halts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hard_reset |->
      out_phase == atxps_pkg::PH_HALT && out_led_disabled && !out_supply_on)
    else $error("hard reset pulse outside a completed shutdown");

  // A soft reset is only asked for while running, never with a hard reset.
  a_soft_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cpu_soft_reset |->
      out_phase == atxps_pkg::PH_RUN && !out_hard_reset)
    else $error("soft reset pulse outside run");

  // Settling implies supply on; the shutdown phases imply supply off.
  a_supply_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_phase != atxps_pkg::PH_SETTLE || out_supply_on) &&
      ((out_phase != atxps_pkg::PH_DROP && out_phase != atxps_pkg::PH_RELEASE &&
        out_phase != atxps_pkg::PH_DEBOUNCE) || !out_supply_on))
    else $error("supply drive disagrees with phase");

  // Every accepted word yields a result word on the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_phase) &&
      $stable(out_hard_reset) && $stable(out_cpu_soft_reset))
    else $error("stalled result word changed");

endmodule

bind atx_power_sequencer atxps_checker u_atxps_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_supply_on      (out_supply_on),
  .out_led_disabled   (out_led_disabled),
  .out_cpu_soft_reset (out_cpu_soft_reset),
  .out_hard_reset     (out_hard_reset),
  .out_phase          (out_phase)
);

/* dv/tb_atx_power_sequencer.sv */
module tb_atx_power_sequencer;

  // Hard ceiling on the run; several times what the slowest legal run needs.
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxReports = 10;

  // Item kinds and reset cause bits as the input channel encodes them.
  localparam logic       KindRestart   = 1'b0;
  localparam logic       KindTick      = 1'b1;
  localparam logic [4:0] CauseNone     = 5'h00;
  localparam logic [4:0] CauseAll      = 5'h1F;
  localparam logic [4:0] CauseExternal = 5'h02;
  localparam logic [4:0] CauseWatchdog = 5'h08;

  // One result word as the block reports it.
  typedef struct packed {
    logic   supply_on;
    logic   led_on;
    logic   led_disabled;
    logic   cpu_soft_reset;
    logic   power_cut;
    atxps_pkg::phase_t phase;
  } status_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [atxps_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [atxps_pkg::CfgDataW-1:0] cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           in_kind = 1'b0;
  logic [4:0]                     in_reset_cause = '0;
  logic                           in_power_absent = 1'b0;
  logic                           in_button_down = 1'b0;
  logic [15:0]                    in_hold_count = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           out_supply_on;
  logic                           out_led_on;
  logic                           out_led_disabled;
  logic                           out_cpu_soft_reset;
  logic                           out_hard_reset;
  logic [2:0]                     out_phase;

  atx_power_sequencer u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_reset_cause     (in_reset_cause),
    .in_power_absent    (in_power_absent),
    .in_button_down     (in_button_down),
    .in_hold_count      (in_hold_count),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_supply_on      (out_supply_on),
    .out_led_on         (out_led_on),
    .out_led_disabled   (out_led_disabled),
    .out_cpu_soft_reset (out_cpu_soft_reset),
    .out_hard_reset     (out_hard_reset),
    .out_phase          (out_phase)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the sequencer: register settings and state, both at block widths.
  // ---------------------------------------------------------------------------
  logic [7:0]  cfg_prewait  = atxps_pkg::PrewaitRst;
  logic [7:0]  cfg_settle   = atxps_pkg::SettleRst;
  logic [15:0] cfg_hold_lim = atxps_pkg::HoldLimRst;
  logic [7:0]  cfg_drop     = atxps_pkg::DropToRst;
  logic [7:0]  cfg_debounce = atxps_pkg::DebounceRst;

  atxps_pkg::phase_t seq_phase = atxps_pkg::PH_HALT;
  logic [7:0]  count_left = '0;
  logic        saw_button = 1'b0;
  logic        shut_by_button = 1'b0;
  logic [15:0] last_hold = '0;
  logic        supply_q = 1'b0;
  logic        led_q = 1'b0;
  logic        led_dark = 1'b0;

  // Status words the block still owes, oldest first.
  status_t     predicted_status[$];
  // Words waiting to be offered on the input channel.
  atxps_pkg::seq_in_t event_queue[$];

  // Traffic shaping, set per phase by the sequence below.
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_off_req = 1'b0;
  int unsigned words_made = 0;

  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;
  bit          word_taken = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_off_left = 0;

  atxps_pkg::seq_in_t fresh_word;
  atxps_pkg::seq_in_t taken_word;
  status_t     seen_status;
  status_t     due_status;

  function automatic void switch_supply_on();
    supply_q   = 1'b1;
    seq_phase  = atxps_pkg::PH_SETTLE;
    count_left = cfg_settle;
  endfunction

  // Advance the shadow by one accepted word and queue the status it must give.
  function automatic void advance_power_fsm(atxps_pkg::seq_in_t w);
    status_t s;
    logic    soft_req;
    logic    hard;
    soft_req = 1'b0;
    hard = 1'b0;
    if (w.kind == KindRestart) begin
      led_q    = 1'b0;
      led_dark = 1'b0;
      if (!w.power_absent) begin
        seq_phase = atxps_pkg::PH_RUN;
      end else if ((w.reset_cause & atxps_pkg::WarmCauses) == 5'd0 || w.reset_cause[0]) begin
        // cold restart without supply: blink first
        seq_phase  = atxps_pkg::PH_PREWAIT;
        count_left = cfg_prewait;
        saw_button = 1'b0;
      end else begin
        switch_supply_on();
      end
    end else begin
      case (seq_phase)
        atxps_pkg::PH_PREWAIT: begin
          led_q = (count_left[2:0] & atxps_pkg::BlinkMask) != 3'd0;
          if (w.button_down) saw_button = 1'b1;
          count_left = count_left - 8'd1;
          if (count_left == 8'd0) begin
            if (saw_button) switch_supply_on();
            else seq_phase = atxps_pkg::PH_AWAIT;
          end
        end
        atxps_pkg::PH_AWAIT: begin
          if (w.button_down) switch_supply_on();
        end
        atxps_pkg::PH_SETTLE: begin
          count_left = count_left - 8'd1;
          if (count_left == 8'd0) seq_phase = atxps_pkg::PH_RUN;
        end
        atxps_pkg::PH_RUN: begin
          if (w.hold_count > cfg_hold_lim) begin
            shut_by_button = w.button_down;
            supply_q       = 1'b0;
            seq_phase      = atxps_pkg::PH_DROP;
            count_left     = cfg_drop;
          end else if (last_hold != 16'd0 && w.hold_count == 16'd0) begin
            soft_req = 1'b1;
          end
          last_hold = w.hold_count;
        end
        atxps_pkg::PH_DROP: begin
          // the timeout only counts while the supply is still seen
          if (!w.power_absent) count_left = count_left - 8'd1;
          if (w.power_absent || count_left == 8'd0) begin
            if (shut_by_button) begin
              seq_phase = atxps_pkg::PH_RELEASE;
            end else begin
              led_dark  = 1'b1;
              seq_phase = atxps_pkg::PH_HALT;
              hard      = 1'b1;
            end
          end
        end
        atxps_pkg::PH_RELEASE: begin
          if (!w.button_down) begin
            seq_phase  = atxps_pkg::PH_DEBOUNCE;
            count_left = cfg_debounce;
          end
        end
        atxps_pkg::PH_DEBOUNCE: begin
          count_left = count_left - 8'd1;
          if (count_left == 8'd0) begin
            led_dark  = 1'b1;
            seq_phase = atxps_pkg::PH_HALT;
            hard      = 1'b1;
          end
        end
        default: ;
      endcase
    end
    s.supply_on      = supply_q;
    s.led_on         = led_q;
    s.led_disabled   = led_dark;
    s.cpu_soft_reset = soft_req;
    s.power_cut      = hard;
    s.phase          = seq_phase;
    predicted_status.push_back(s);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  function automatic void push_word(logic k, logic [4:0] c, logic a, logic b, logic [15:0] h);
    atxps_pkg::seq_in_t w;
    w.kind         = k;
    w.reset_cause  = c;
    w.power_absent = a;
    w.button_down  = b;
    w.hold_count   = h;
    event_queue.push_back(w);
    words_made++;
  endfunction

  // Ticks a counter register really lasts: zero wraps to a full 256.
  function automatic int unsigned span(logic [7:0] v);
    return (v == 8'd0) ? 256 : int'(v);
  endfunction

  function automatic logic [15:0] pick_hold();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return 16'd0;
    if (r < 75) return 16'($urandom_range(1, 40));
    if (r < 85) return cfg_hold_lim;
    if (r < 95) return 16'($urandom_range(0, cfg_hold_lim));
    return 16'($urandom);
  endfunction

  function automatic logic coin(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  // Queue one power cycle: restart, blink, settle, run, shutdown, debounce.
  // Ignored fields carry random noise; now and then a burst of pure noise
  // words (restarts included) lands in whatever phase the block is in.
  function automatic void queue_episode();
    int unsigned btn_pct;
    int unsigned n;
    logic [4:0]  cause;
    logic        absent;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 8))
        push_word(1'($urandom), 5'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
      return;
    end
    case ($urandom_range(2))
      0:       btn_pct = 0;
      1:       btn_pct = 15;
      default: btn_pct = 70;
    endcase
    cause  = 5'($urandom);
    absent = coin(80);
    push_word(KindRestart, cause, absent, 1'($urandom), 16'($urandom));
    if (absent) begin
      if ((cause & atxps_pkg::WarmCauses) == 5'd0 || cause[0]) begin
        n = span(cfg_prewait);
        repeat (n)
          push_word(KindTick, 5'($urandom), 1'($urandom), coin(btn_pct), 16'($urandom));
        // press in the await phase unless it was already caught while blinking
        repeat ($urandom_range(0, 3))
          push_word(KindTick, 5'($urandom), 1'($urandom), 1'b0, 16'($urandom));
        push_word(KindTick, 5'($urandom), 1'($urandom), 1'b1, 16'($urandom));
      end
      n = span(cfg_settle);
      repeat (n)
        push_word(KindTick, 5'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
    end
    repeat ($urandom_range(0, 10))
      push_word(KindTick, 5'($urandom), 1'($urandom), coin(30), pick_hold());
    if (cfg_hold_lim == 16'hFFFF) return;
    push_word(KindTick, 5'($urandom), 1'($urandom), 1'($urandom),
              16'($urandom_range(int'(cfg_hold_lim) + 1, 65535)));
    if (span(cfg_drop) <= 12 && $urandom_range(3) == 0) begin
      // let the drop timeout run out
      repeat (span(cfg_drop))
        push_word(KindTick, 5'($urandom), 1'b0, 1'($urandom), 16'($urandom));
    end else begin
      repeat ($urandom_range(0, 4))
        push_word(KindTick, 5'($urandom), 1'b0, 1'($urandom), 16'($urandom));
      push_word(KindTick, 5'($urandom), 1'b1, 1'($urandom), 16'($urandom));
    end
    repeat ($urandom_range(0, 3))
      push_word(KindTick, 5'($urandom), 1'($urandom), 1'b1, 16'($urandom));
    push_word(KindTick, 5'($urandom), 1'($urandom), 1'b0, 16'($urandom));
    repeat (span(cfg_debounce))
      push_word(KindTick, 5'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
    repeat ($urandom_range(0, 2))
      push_word(KindTick, 5'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
  endfunction

  // Fill the queue with whole episodes, then drop the tail past the budget.
  function automatic void queue_random(int unsigned budget);
    words_made = 0;
    while (words_made < budget) queue_episode();
    while (words_made > budget) begin
      void'(event_queue.pop_back());
      words_made--;
    end
  endfunction

  // Write one register; cfg_we stays high across back-to-back writes.
  task automatic write_reg(atxps_pkg::cfg_idx_t idx, logic [atxps_pkg::CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      atxps_pkg::CFG_PREWAIT:  cfg_prewait  = val[7:0];
      atxps_pkg::CFG_SETTLE:   cfg_settle   = val[7:0];
      atxps_pkg::CFG_HOLD_LIM: cfg_hold_lim = val;
      atxps_pkg::CFG_DROP_TO:  cfg_drop     = val[7:0];
      atxps_pkg::CFG_DEBOUNCE: cfg_debounce = val[7:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(logic [7:0] prew, logic [7:0] settle, logic [15:0] lim,
                               logic [7:0] drop, logic [7:0] deb);
    write_reg(atxps_pkg::CFG_PREWAIT, {8'd0, prew});
    write_reg(atxps_pkg::CFG_SETTLE, {8'd0, settle});
    write_reg(atxps_pkg::CFG_HOLD_LIM, lim);
    write_reg(atxps_pkg::CFG_DROP_TO, {8'd0, drop});
    write_reg(atxps_pkg::CFG_DEBOUNCE, {8'd0, deb});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every queued word is sent and every status word has come back,
  // then let the last registered result clear before touching registers.
  task automatic drain();
    while (event_queue.size() != 0 || in_valid || predicted_status.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: change at the falling edge, hold each word until taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_valid || word_taken)) begin
      word_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (event_queue.size() == 0) begin
        in_valid <= 1'b0;
      end else if (coin(gap_pct)) begin
        send_gap = $urandom_range(0, 6);
        in_valid <= 1'b0;
      end else begin
        fresh_word = event_queue.pop_front();
        in_valid        <= 1'b1;
        in_kind         <= fresh_word.kind;
        in_reset_cause  <= fresh_word.reset_cause;
        in_power_absent <= fresh_word.power_absent;
        in_button_down  <= fresh_word.button_down;
        in_hold_count   <= fresh_word.hold_count;
      end
    end
  end

  // Result back-pressure: short random stalls, plus one long hold-off on request
  // so the output register fills and in_ready drops while words keep coming.
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_ready <= 1'b0;
    end else if (hold_off_req) begin
      hold_off_req  = 1'b0;
      hold_off_left = 99;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (coin(stall_pct)) begin
      stall_left = $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample both handshakes at the rising edge, predict and compare.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else if (rst_n) begin
      if (in_valid && in_ready) begin
        taken_word.kind         = in_kind;
        taken_word.reset_cause  = in_reset_cause;
        taken_word.power_absent = in_power_absent;
        taken_word.button_down  = in_button_down;
        taken_word.hold_count   = in_hold_count;
        advance_power_fsm(taken_word);
        word_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        seen_status.supply_on      = out_supply_on;
        seen_status.led_on         = out_led_on;
        seen_status.led_disabled   = out_led_disabled;
        seen_status.cpu_soft_reset = out_cpu_soft_reset;
        seen_status.power_cut      = out_hard_reset;
        seen_status.phase          = atxps_pkg::phase_t'(out_phase);
        if (predicted_status.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("cycle %0d: status word with none due: %p", cycle_count, seen_status);
        end else begin
          due_status = predicted_status.pop_front();
          if (seen_status !== due_status) begin
            fail_count++;
            if (fail_count <= MaxReports)
              $display({"cycle %0d: status mismatch supply/led/led_off/soft/hard/phase ",
                        "expected %b/%b/%b/%b/%b/%0d got %b/%b/%b/%b/%b/%0d"},
                       cycle_count,
                       due_status.supply_on, due_status.led_on, due_status.led_disabled,
                       due_status.cpu_soft_reset, due_status.power_cut, due_status.phase,
                       seen_status.supply_on, seen_status.led_on, seen_status.led_disabled,
                       seen_status.cpu_soft_reset, seen_status.power_cut, seen_status.phase);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed walk under the reset settings: halted tick, straight to run,
    // soft reset on release, hold exactly at and just past the limit, the
    // button-led shutdown through release and debounce, warm and cold
    // restarts, a stale hold count giving a soft reset, and a shutdown that
    // finishes in the tick that sees the supply gone.
    gap_pct   = 20;
    stall_pct = 20;
    push_word(KindTick, CauseAll, 1'b1, 1'b1, 16'hFFFF);
    push_word(KindRestart, CauseNone, 1'b0, 1'b0, 16'd0);
    push_word(KindTick, CauseNone, 1'b0, 1'b0, 16'd5);
    push_word(KindTick, CauseNone, 1'b0, 1'b0, 16'd0);
    push_word(KindTick, CauseNone, 1'b0, 1'b0, 16'd1700);
    push_word(KindTick, CauseNone, 1'b0, 1'b1, 16'd1701);
    push_word(KindTick, CauseNone, 1'b0, 1'b1, 16'd0);
    push_word(KindTick, CauseNone, 1'b1, 1'b1, 16'd0);
    push_word(KindTick, CauseNone, 1'b0, 1'b1, 16'd0);
    push_word(KindTick, CauseNone, 1'b0, 1'b0, 16'd0);
    repeat (10) push_word(KindTick, CauseNone, 1'b0, 1'b1, 16'd0);
    push_word(KindTick, CauseNone, 1'b0, 1'b0, 16'd0);
    push_word(KindRestart, CauseExternal, 1'b1, 1'b0, 16'd0);
    push_word(KindRestart, CauseAll, 1'b1, 1'b0, 16'd0);
    push_word(KindTick, CauseNone, 1'b0, 1'b1, 16'd0);
    push_word(KindRestart, CauseWatchdog, 1'b0, 1'b0, 16'd0);
    push_word(KindTick, CauseNone, 1'b0, 1'b0, 16'd0);
    push_word(KindTick, CauseNone, 1'b0, 1'b0, 16'hFFFF);
    push_word(KindTick, CauseNone, 1'b1, 1'b0, 16'd0);
    drain();

    // Reset settings, random; the long receiver hold-off lands here.
    gap_pct   = 30;
    stall_pct = 30;
    queue_random(250);
    hold_off_req = 1'b1;
    drain();

    // Lowest settings: one-tick counters, any nonzero hold shuts down.
    load_settings(8'd1, 8'd1, 16'd0, 8'd1, 8'd1);
    gap_pct   = 0;
    stall_pct = 40;
    queue_random(150);
    drain();

    // Highest settings: no hold count can exceed the limit.
    load_settings(8'd255, 8'd255, 16'hFFFF, 8'd255, 8'd255);
    gap_pct   = 40;
    stall_pct = 0;
    queue_random(550);
    drain();

    // Zero in the settle, drop and debounce counters: each lasts a full 256 ticks.
    load_settings(8'd1, 8'd0, 16'($urandom_range(0, 3000)), 8'd0, 8'd0);
    gap_pct   = 15;
    stall_pct = 15;
    queue_random(550);
    drain();

    // Short random settings; the last round runs with no idling at all.
    for (int round = 0; round < 5; round++) begin
      load_settings(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                    (round % 2) ? 16'($urandom_range(0, 80)) : 16'($urandom),
                    8'($urandom_range(1, 8)), 8'($urandom_range(1, 6)));
      gap_pct   = (round == 4) ? 0 : $urandom_range(0, 40);
      stall_pct = (round == 4) ? 0 : $urandom_range(0, 40);
      queue_random(90);
      drain();
    end

    repeat (8) @(posedge clk);
    if (predicted_status.size() != 0) fail_count += predicted_status.size();
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
